@@ sv/sorted_key_table_macros.svh @@
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Shared property forms for the checker of the sorted key table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define SKT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_key_table: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define SKT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_key_table: next-cycle check failed");

`endif

@@ sv/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, command codes and the types shared by the table cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BYTES = 8;

  localparam int KEY_W     = KEY_BYTES * 8;
  localparam int NAME_W    = 64;
  localparam int AGE_W     = 8;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;
  // Internal fill count, wide enough to hold ENTRIES itself.
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } skt_cmd_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } skt_entry_t;

  // Broadcast to every cell for the item being accepted.
  typedef struct packed {
    skt_cmd_e         cmd;
    logic             we;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } skt_ctrl_t;

endpackage

`default_nettype wire

@@ sv/skt_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one (key, age) slot, compares it with the broadcast key and takes
// its left or right neighbor's slot when the table shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell (
  input  wire logic               clk_i,
  input  wire skt_pkg::skt_ctrl_t ctrl_i,
  input  wire logic               occupied_i,
  input  wire logic               chain_i,
  input  wire skt_pkg::skt_entry_t left_i,
  input  wire skt_pkg::skt_entry_t right_i,
  output      skt_pkg::skt_entry_t entry_o,
  output      logic               chain_o
);
  import skt_pkg::*;

  skt_entry_t entry_q, entry_d;
  logic       greater;
  logic       hit;

  // On insert the chain bit marks slots at or after the insertion point.
  // Since the table is sorted and the free slots sit at the top, it is a
  // thermometer code. On delete it marks the first match and everything above.
  assign greater = !occupied_i || (entry_q.key > ctrl_i.key);
  assign hit     = occupied_i && (entry_q.key == ctrl_i.key);

  always_comb begin
    if (ctrl_i.cmd == CMD_DELETE) begin
      chain_o = chain_i || hit;
    end else begin
      chain_o = greater;
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.we) begin
      if (ctrl_i.cmd == CMD_DELETE) begin
        if (chain_o) begin
          entry_d = right_i;
        end
      end else if (chain_i) begin
        entry_d = left_i;
      end else if (greater) begin
        entry_d.key = ctrl_i.key;
        entry_d.age = ctrl_i.age;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ sv/sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// Sorted key table
// A table of (key, age) pairs kept in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one command per item: insert a (key, age) pair,
//   or delete the first entry with a matching key. Every item produces exactly
//   one result item with success, the slot used and the count afterwards.
//   A full table refuses inserts; a missing key fails a delete. Both then
//   report position 0 and leave the table untouched.
//   The result is valid in the cycle after the command is accepted.
//   Throughput is one item per cycle unless stalled; every cell compares its
//   slot with the key and shifts to its neighbor in that same cycle, so the
//   ripple of the match chain across all cells sets the clock period.
//   The result sits in an output register; while it waits, in_ready_o stays
//   high only if out_ready_i is high in the same cycle, so a stalled receiver
//   holds back the next item without losing anything.
//   Reset empties the table at once (the fill count clears); the slots
//   themselves are not cleared and are only read below the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic                        command_i,
  input  wire logic [skt_pkg::NAME_W-1:0]  name_key_i,
  input  wire logic [skt_pkg::AGE_W-1:0]   age_value_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic                        success_o,
  output      logic [skt_pkg::POS_W-1:0]   position_o,
  output      logic [skt_pkg::COUNT_W-1:0] entry_count_o
);
  import skt_pkg::*;

  skt_ctrl_t         ctrl;
  skt_entry_t        entries [ENTRIES];
  logic [ENTRIES-1:0] chain;
  logic [ENTRIES-1:0] occupied;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic              success_q;
  logic [POS_W-1:0]  position_q;
  logic [COUNT_W-1:0] entry_count_q;

  logic              accept;
  logic              full;
  logic              found;
  logic              success;
  logic [CNT_W-1:0]  slot;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == CNT_W'(ENTRIES));
  assign found = chain[ENTRIES-1];

  always_comb begin
    ctrl.cmd = skt_cmd_e'(command_i);
    ctrl.key = name_key_i[KEY_W-1:0];
    ctrl.age = age_value_i;
    if (ctrl.cmd == CMD_DELETE) begin
      success = found;
    end else begin
      success = !full;
    end
    ctrl.we = accept && success;
  end

  // Cells below the first chain bit are the ones kept in place; their number
  // is the slot that was written or removed.
  assign slot = success ? CNT_W'($countones(~chain)) : '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    skt_entry_t left_e, right_e;
    logic       chain_in;

    assign occupied[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_e   = '0;
      assign chain_in = 1'b0;
    end else begin : g_inner
      assign left_e   = entries[i-1];
      assign chain_in = chain[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_body
      assign right_e = entries[i+1];
    end

    skt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occupied[i]),
      .chain_i    (chain_in),
      .left_i     (left_e),
      .right_i    (right_e),
      .entry_o    (entries[i]),
      .chain_o    (chain[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.we) begin
      if (ctrl.cmd == CMD_DELETE) begin
        count_d = count_q - CNT_W'(1);
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      success_q     <= success;
      position_q    <= POS_W'(slot);
      entry_count_q <= COUNT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = success_q;
  assign position_o    = position_q;
  assign entry_count_o = entry_count_q;

endmodule

`default_nettype wire

@@ sv/skt_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted key table checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_macros.svh"

module skt_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_o,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire logic                        success_o,
  input  wire logic [skt_pkg::POS_W-1:0]   position_o,
  input  wire logic [skt_pkg::COUNT_W-1:0] entry_count_o
);
  import skt_pkg::*;

  logic in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  // Every accepted item yields a result in the next cycle.
  `SKT_ASSERT_NXT(a_result_follows, in_accept, out_valid_o)

  // No item enters while a result is held back by the receiver.
  `SKT_ASSERT_IMP(a_no_accept_in_stall, out_valid_o && !out_ready_i, !in_ready_o)

  // A refused command reports slot zero.
  `SKT_ASSERT_IMP(a_fail_pos_zero, out_valid_o && !success_o, position_o == '0)

  // A stalled result holds its payload.
  `SKT_ASSERT_NXT(a_stall_holds, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(success_o) && $stable(position_o) &&
                  $stable(entry_count_o))

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);

`default_nettype wire
